### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the chroma subsampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/c420w_pkg.sv
// ----------------------------------------------------------------------------
// c420w_pkg
// Shared constants and types of the weighted 4:4:4 to 4:2:0 chroma subsampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c420w_pkg;

   localparam int C420W_MAX_WIDTH = 4096;

   localparam int DIM_W    = 13;  // plane_width, plane_height and the counters
   localparam int SAMPLE_W = 8;
   localparam int PSUM_W   = 10;  // a + 3*b, at most 1020
   localparam int ACC_W    = 12;  // full weighted sum, at most 4088

   // Register indexes of the configuration port.
   localparam logic REG_PLANE_WIDTH  = 1'b0;
   localparam logic REG_PLANE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                frame_end;
   } result_type;

endpackage

### rtl/core/chroma_444_to_420_weighted.sv
// ----------------------------------------------------------------------------
// chroma_444_to_420_weighted
// Weighted 2x2 chroma subsampler from a raster sample stream to 4:2:0.
// ----------------------------------------------------------------------------
// Usage:
//   Samples of one chroma plane enter on the req_ channel in raster order,
//   one per transfer. For each complete 2x2 block the rsp_ channel carries
//   (tl + 3*(tr + bl) + 9*br + 8) >> 4; rsp_tlast marks the plane's last
//   block. Planes follow back to back. An odd last column or row is dropped,
//   and a plane narrower or shorter than 2 produces nothing.
//   plane_width and plane_height are written on the csr_ port while the
//   block is idle; reset clears both, so nothing is emitted until written.
//   Throughput is one sample per cycle while the output buffer has room. A
//   result is pushed into that buffer when the bottom-right sample of its
//   block is taken. The line store is read when the bottom-left sample
//   arrives and its registered output is used with the bottom-right one.
//   A two-entry output buffer absorbs receiver stalls: input keeps flowing
//   until both entries are full, and no result is lost or repeated.
//   Reset is synchronous and clears the counters and the buffer; the line
//   store needs no clearing because every entry a result uses is written first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chroma_444_to_420_weighted #(
   parameter int MAX_WIDTH = c420w_pkg::C420W_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   // Sample stream.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] sample
   // Result stream.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] value
   output logic                         rsp_tlast,   // frame_end
   // Configuration writes.
   input  logic                         csr_we,
   input  logic                         csr_addr,
   input  logic [c420w_pkg::DIM_W-1:0]  csr_wdata
);
   import c420w_pkg::*;

   localparam int PAIR_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W     = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
   localparam int MW_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W      = (MW_BITS > DIM_W + 1) ? MW_BITS : DIM_W + 1;

   logic [DIM_W-1:0]    plane_width_ff, plane_height_ff;
   logic [SAMPLE_W-1:0] held_ff, held_in;
   logic [DIM_W-1:0]    col_ff, col_in;
   logic [DIM_W-1:0]    row_ff, row_in;

   logic                accept, small_plane, pair_ok, emit;
   logic [CMP_W-1:0]    eff_w, eff_w_even, col_ext, last_col;
   logic [DIM_W-1:0]    last_row;
   logic [SAMPLE_W-1:0] sample;
   logic [ADDR_W-1:0]   pair_addr;
   logic                mem_we, mem_re;
   logic [PSUM_W-1:0]   mem_wdata, mem_rdata;
   logic [ACC_W-1:0]    block_sum;
   logic                fifo_room;
   result_type          result, rsp_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_width_ff  <= '0;
         plane_height_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_PLANE_WIDTH:  plane_width_ff  <= csr_wdata;
            REG_PLANE_HEIGHT: plane_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sample      = req_tdata;
   assign req_tready  = fifo_room;
   assign accept      = req_tvalid && req_tready;
   assign small_plane = (plane_width_ff < DIM_W'(2)) || (plane_height_ff < DIM_W'(2));

   assign eff_w = (CMP_W'(plane_width_ff) > CMP_W'(MAX_WIDTH)) ?
                  CMP_W'(MAX_WIDTH) : CMP_W'(plane_width_ff);
   assign eff_w_even = {eff_w[CMP_W-1:1], 1'b0};
   assign col_ext    = CMP_W'(col_ff);
   assign last_col   = eff_w_even - CMP_W'(1);
   assign last_row   = {plane_height_ff[DIM_W-1:1], 1'b0} - DIM_W'(1);
   assign pair_addr  = ADDR_W'(col_ff >> 1);

   // A right-hand sample inside the even-width region completes a column pair.
   assign pair_ok = col_ff[0] && (col_ext < eff_w_even);

   // Top rows store a + 3b; bottom rows fetch it on the left sample and
   // finish the block on the right sample.
   assign mem_we    = accept && !small_plane && pair_ok && !row_ff[0];
   assign mem_wdata = PSUM_W'(held_ff) + PSUM_W'(3) * PSUM_W'(sample);
   assign mem_re    = accept && !small_plane && !col_ff[0] && row_ff[0];
   assign emit      = accept && !small_plane && pair_ok && row_ff[0];

   assign block_sum = ACC_W'(mem_rdata) + ACC_W'(3) * ACC_W'(held_ff)
                    + ACC_W'(9) * ACC_W'(sample) + ACC_W'(8);

   assign result.value     = block_sum[ACC_W-1:4];
   assign result.frame_end = (row_ff == last_row) && (col_ext == last_col);

   always_comb begin
      held_in = held_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept && !small_plane) begin
         if (!col_ff[0]) begin
            held_in = sample;
         end
         if ((DIM_W + 1)'(col_ff) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(plane_width_ff)) begin
            col_in = '0;
            if ((DIM_W + 1)'(row_ff) + (DIM_W + 1)'(1) >=
                (DIM_W + 1)'(plane_height_ff)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + DIM_W'(1);
            end
         end else begin
            col_in = col_ff + DIM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         held_ff <= held_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   c420w_line_mem #(
      .DEPTH  (PAIR_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (pair_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (pair_addr),
      .rd_data (mem_rdata)
   );

   c420w_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .has_room  (fifo_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data.value;
   assign rsp_tlast = rsp_data.frame_end;

   `ASSERT_NXT(a_emit_shows, clock, reset, emit, rsp_tvalid)
   `ASSERT_NXT(a_small_holds, clock, reset, accept && small_plane,
      $stable(col_ff) && $stable(row_ff))
   `ASSERT_IMP(a_mem_one_op, clock, reset, 1'b1, !(mem_we && mem_re))

endmodule

### rtl/core/c420w_line_mem.sv
// ----------------------------------------------------------------------------
// c420w_line_mem
// Line store of column-pair partial sums: one write port, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c420w_line_mem #(
   parameter int DEPTH  = c420w_pkg::C420W_MAX_WIDTH / 2,
   parameter int ADDR_W = 11
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [c420w_pkg::PSUM_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [c420w_pkg::PSUM_W-1:0]  rd_data
);
   import c420w_pkg::*;

   logic [PSUM_W-1:0] mem [DEPTH];
   logic [PSUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data holds until the next read, so a late partner sample still
   // finds it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/c420w_out_fifo.sv
// ----------------------------------------------------------------------------
// c420w_out_fifo
// Two-entry result buffer that decouples the core from receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c420w_out_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  c420w_pkg::result_type    push_data,
   output logic                     has_room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output c420w_pkg::result_type    out_data
);
   import c420w_pkg::*;

   result_type data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign has_room  = !count_ff[1];
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMP(a_no_push_when_full, clock, reset, push, !count_ff[1])
   `ASSERT_IMP(a_count_bounded, clock, reset, 1'b1, count_ff != 2'd3)
   `ASSERT_NXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

### dv/c420w_block_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c420w_block_checker
// Watches the sample, result and register ports of the weighted 4:2:0
// subsampler, predicts each 2x2 block average from the accepted samples and
// compares every result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module c420w_block_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,    // [7:0] sample
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [7:0]                    rsp_tdata,    // [7:0] value
   input  logic                          rsp_tlast,    // frame_end
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [c420w_pkg::DIM_W-1:0]   csr_wdata,
   output int                            mismatches,
   output int                            blocks_pending,
   output int                            blocks_checked,
   output int                            planes_done
);
   import c420w_pkg::*;

   logic [DIM_W-1:0]    plane_w;
   logic [DIM_W-1:0]    plane_h;
   logic [DIM_W-1:0]    col_pos;
   logic [DIM_W-1:0]    row_pos;
   logic [SAMPLE_W-1:0] left_sample;
   logic [PSUM_W-1:0]   top_pair_sum [C420W_MAX_WIDTH/2];
   result_type          block_averages [$];
   int                  fail_total = 0;

   assign mismatches = fail_total;

   task automatic report(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      fail_total++;
   endtask

   // Unless the plane is under 2 wide or high, advances the raster position by
   // one sample and queues the block average when it closes a bottom-row 2x2 block.
   task automatic take_sample(input logic [SAMPLE_W-1:0] s);
      int unsigned w, h, c, r, eff_w, acc;
      result_type  blk;
      w = plane_w;
      h = plane_h;
      c = col_pos;
      r = row_pos;
      if (w < 2 || h < 2) return;
      eff_w = (w > C420W_MAX_WIDTH) ? C420W_MAX_WIDTH : w;
      if (c % 2 == 0) begin
         left_sample = s;
      end else if (c < (eff_w & ~32'd1)) begin
         if (r % 2 == 0) begin
            top_pair_sum[c >> 1] = PSUM_W'(left_sample + 3 * s);
         end else begin
            acc = top_pair_sum[c >> 1] + 3 * left_sample + 9 * s + 8;
            blk.value     = SAMPLE_W'(acc >> 4);
            blk.frame_end = (r == (h & ~32'd1) - 1) && (c == (eff_w & ~32'd1) - 1);
            block_averages.push_back(blk);
         end
      end
      if (c + 1 >= w) begin
         col_pos = '0;
         row_pos = (r + 1 >= h) ? '0 : DIM_W'(r + 1);
      end else begin
         col_pos = DIM_W'(c + 1);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         plane_w     = '0;
         plane_h     = '0;
         col_pos     = '0;
         row_pos     = '0;
         left_sample = '0;
         block_averages.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (block_averages.size() == 0) begin
               report($sformatf("result transfer value %0d last %0b with nothing expected",
                                rsp_tdata, rsp_tlast));
            end else begin
               want = block_averages.pop_front();
               if (rsp_tdata !== want.value)
                  report($sformatf("value %0d, expected %0d", rsp_tdata, want.value));
               if (rsp_tlast !== want.frame_end)
                  report($sformatf("frame end %0b, expected %0b", rsp_tlast, want.frame_end));
               blocks_checked <= blocks_checked + 1;
               if (want.frame_end) planes_done <= planes_done + 1;
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_PLANE_WIDTH:  plane_w = csr_wdata;
               REG_PLANE_HEIGHT: plane_h = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_sample(req_tdata);
      end
      blocks_pending <= block_averages.size();
   end

endmodule

### dv/chroma_444_to_420_weighted_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_444_to_420_weighted_tb
// Drives chroma planes of many shapes into the weighted 4:2:0 subsampler:
// a few directed planes, then random planes with random sender gaps and
// receiver stalls. A checker beside the block predicts and compares every
// result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module chroma_444_to_420_weighted_tb;
   import c420w_pkg::*;

   localparam int RUN_LIMIT      = 200_000;
   localparam int RANDOM_SAMPLES = 1400;
   localparam int CALM_TAIL      = 150;
   localparam int SETTLE_CYCLES  = 4;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;
   logic             csr_we     = 1'b0;
   logic             csr_addr   = REG_PLANE_WIDTH;
   logic [DIM_W-1:0] csr_wdata  = '0;

   logic calm = 1'b0;   // no idling on either side
   int   cycle_count = 0;
   int   samples_sent = 0;
   int   random_samples = 0;
   int   mismatches, blocks_pending, blocks_checked, planes_done;

   chroma_444_to_420_weighted uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   c420w_block_checker block_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .blocks_pending (blocks_pending),
      .blocks_checked (blocks_checked),
      .planes_done    (planes_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, blocks_pending);
      $display("chroma_444_to_420_weighted verification failed");
      $finish;
   end

   // Receiver: random ready spans and stall bursts until the calm tail, then ready.
   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] pick_sample();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [7:0] s);
      if (!calm && $urandom_range(7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic send_plane(input int unsigned w, input int unsigned h);
      for (int unsigned i = 0; i < w * h; i++) send_sample(pick_sample());
   endtask

   // Drops valid, lets every predicted result drain, then settles for samples
   // that produce nothing but may still be inside the block.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blocks_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_plane(input int unsigned w, input int unsigned h);
      csr_we    <= 1'b1;
      csr_addr  <= REG_PLANE_WIDTH;
      csr_wdata <= DIM_W'(w);
      @(posedge clock);
      csr_addr  <= REG_PLANE_HEIGHT;
      csr_wdata <= DIM_W'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int unsigned w, h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Nothing is configured after reset, so samples are dropped.
      send_sample(8'hA5);
      wait_idle();
      set_plane(0, 4096);
      send_sample(8'h5A);
      wait_idle();
      set_plane(4096, 1);
      send_sample(8'hFF);
      wait_idle();

      // Full-scale block, then one weighting the two middle neighbors only.
      set_plane(2, 2);
      repeat (4) send_sample(8'hFF);
      send_sample(8'h00);
      send_sample(8'hFF);
      send_sample(8'hFF);
      send_sample(8'h00);
      wait_idle();

      // Odd last column, then a smaller height written between the row pairs
      // so that the third row becomes an odd last row.
      set_plane(3, 4);
      repeat (6) send_sample(pick_sample());
      wait_idle();
      set_plane(3, 3);
      repeat (3) send_sample(pick_sample());
      wait_idle();

      while (random_samples < RANDOM_SAMPLES) begin
         case ($urandom_range(19))
            0: begin
               w = $urandom_range(1);
               h = $urandom_range(9);
               if ($urandom_range(1)) {w, h} = {h, w};
               wait_idle();
               set_plane(w, h);
               repeat ($urandom_range(4, 1)) send_sample(pick_sample());
            end
            1, 2: begin
               w = $urandom_range(100, 13);
               h = $urandom_range(3, 2);
               wait_idle();
               set_plane(w, h);
               send_plane(w, h);
               random_samples += w * h;
            end
            default: begin
               w = $urandom_range(12, 2);
               h = $urandom_range(9, 2);
               wait_idle();
               set_plane(w, h);
               // Planes of one shape follow back to back.
               repeat ($urandom_range(3, 1)) begin
                  send_plane(w, h);
                  random_samples += w * h;
               end
            end
         endcase
         if (random_samples >= RANDOM_SAMPLES - CALM_TAIL) calm = 1'b1;
      end
      wait_idle();

      $display("Sent %0d samples: directed blocks and %0d random samples.",
               samples_sent, random_samples);
      $display("Checked %0d block averages across %0d complete planes.",
               blocks_checked, planes_done);
      if (mismatches == 0) begin
         $display("chroma_444_to_420_weighted verification clean");
      end else begin
         $display("chroma_444_to_420_weighted verification failed");
      end
      $finish;
   end

endmodule

### chroma_444_to_420_weighted.f
+incdir+rtl/core
rtl/core/c420w_pkg.sv
rtl/core/c420w_line_mem.sv
rtl/core/c420w_out_fifo.sv
rtl/core/chroma_444_to_420_weighted.sv
dv/c420w_block_checker.sv
dv/chroma_444_to_420_weighted_tb.sv
